>>> hdl/latency_histogram_percentile_stats_top_defines.svh
// Assertion macros shared by the statistics block.
`ifndef LATENCY_HISTOGRAM_PERCENTILE_STATS_TOP_DEFINES_SVH
`define LATENCY_HISTOGRAM_PERCENTILE_STATS_TOP_DEFINES_SVH
// Check a property on the rising clock edge outside reset.
`define LHPS_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Check that a condition never holds outside reset.
`define LHPS_NEVER(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`endif

>>> hdl/lhps_pkg.sv
// Types and constants of the latency histogram statistics block.
`default_nettype none
package lhps_pkg;
  typedef enum logic [2:0] {
    OP_DELIVERED = 3'd0,
    OP_PARTS     = 3'd1,
    OP_USEFUL    = 3'd2,
    OP_PART_RCV  = 3'd3,
    OP_SNAPSHOT  = 3'd4
  } op_e;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RMW,
    ST_SCAN_P,
    ST_CUT_P,
    ST_SCAN_L,
    ST_DIV,
    ST_PACK,
    ST_OUT
  } state_e;

  localparam logic [30:0] SAT31 = 31'h7FFF_FFFF;
  localparam logic [31:0] SAT32 = 32'hFFFF_FFFF;
  localparam logic [63:0] SAT64 = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam int unsigned PCT   = 100;
  // Latency buckets per class; the bucket index splits cleanly at a power of two.
  localparam int unsigned LAT_BUCKETS = 1024;

  // One divider request: 64-bit dividend over 64-bit divisor.
  typedef struct packed {
    logic        start;
    logic [63:0] num;
    logic [63:0] den;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] quo;
  } div_rsp_t;
endpackage
`default_nettype wire

>>> hdl/lhps_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
`default_nettype none
module lhps_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256
) (
  input  wire                        clk_i,
  input  wire                        we_i,
  input  wire  [$clog2(DEPTH)-1:0]   waddr_i,
  input  wire  [WIDTH-1:0]           wdata_i,
  input  wire  [$clog2(DEPTH)-1:0]   raddr_i,
  output logic [WIDTH-1:0]           rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

>>> hdl/lhps_div.sv
// Restoring divider, one quotient bit per cycle.
`default_nettype none
module lhps_div (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  lhps_pkg::div_req_t   req_i,
  output lhps_pkg::div_rsp_t   rsp_o
);
  import lhps_pkg::*;

  logic [63:0] rem_q, rem_d, quo_q, quo_d, den_q, den_d;
  logic [6:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d, done_q, done_d;
  logic [64:0] trial;

  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial  = {rem_q, quo_q[63]} - {1'b0, den_q};
    if (req_i.start) begin
      rem_d  = '0;
      quo_d  = req_i.num;
      den_d  = req_i.den;
      cnt_d  = 7'd64;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!trial[64]) begin
        rem_d = trial[63:0];
        quo_d = {quo_q[62:0], 1'b1};
      end else begin
        rem_d = {rem_q[62:0], quo_q[63]};
        quo_d = {quo_q[62:0], 1'b0};
      end
      cnt_d = cnt_q - 7'd1;
      if (cnt_q == 7'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    den_q <= den_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quo  = quo_q;
endmodule
`default_nettype wire

>>> hdl/latency_histogram_percentile_stats_top.sv
// Top level of the latency histogram percentile statistics block.
// Each event item is a histogram read, then an increment and write back.
// A snapshot walks the parts histogram twice (up to limit+1 buckets a pass), the latency
// histogram once and runs four divisions. Reset and every snapshot clear the histograms,
// a limit change clears the parts histogram; no item is taken meanwhile.
`default_nettype none
module latency_histogram_percentile_stats_top #(
  parameter int unsigned MAX_PARTS    = 255,
  parameter int unsigned AVG_LIMIT    = 32767,
  parameter int unsigned P99_LIMIT    = 1024,
  parameter int unsigned MAX_MS_LIMIT = 32767,
  parameter int unsigned REPAIR_SCALE = 100
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         in_valid_i,
  output logic        in_stall_o,
  input  wire  [2:0]  operation_i,
  input  wire  [15:0] parts_i,
  input  wire  [31:0] duration_ms_i,
  input  wire         is_slot0_i,
  input  wire         via_repair_i,
  output logic        out_valid_o,
  input  wire         out_stall_i,
  output logic [30:0] delivered_count_o,
  output logic [7:0]  parts_low_cutoff_o,
  output logic [30:0] avg_pair_o,
  output logic [30:0] max_and_repair_o,
  output logic [30:0] p99_pair_o,
  input  wire         cfg_valid_i,
  output logic        cfg_ready_o,
  input  wire  [7:0]  cfg_data_i
);
  import lhps_pkg::*;
  `include "latency_histogram_percentile_stats_top_defines.svh"

  localparam int unsigned PDEPTH = 256;
  localparam int unsigned LDEPTH = 2 * LAT_BUCKETS;
  localparam int unsigned LAW    = $clog2(LDEPTH);
  localparam int unsigned CLRN   = (LDEPTH > PDEPTH) ? LDEPTH : PDEPTH;
  localparam int unsigned CW     = $clog2(CLRN) + 1;
  localparam logic [7:0]  EFF_MAX = (MAX_PARTS > 255) ? 8'd255 : 8'(MAX_PARTS);

  state_e state_q, state_d;

  logic [7:0]  limit_q;
  logic [63:0] deliv_q;
  logic [63:0] lcnt_q [2];
  logic [63:0] lsum_q [2];
  logic [31:0] lpeak_q [2];
  logic [31:0] rtot_q [2];
  logic [31:0] rhit_q [2];
  // count/100 kept alongside each count: quotient and remainder
  logic [63:0] ldq_q [2];
  logic [6:0]  ldr_q [2];
  logic [63:0] pdq_q;
  logic [6:0]  pdr_q;

  // latched item
  logic [2:0]  op_q;
  logic [15:0] parts_q;
  logic [31:0] dur_q;
  logic        cls_q, rep_q;

  logic [CW-1:0] clr_q;
  logic          pclr_q; // parts-only clear sweep
  logic [LAW:0]  idx_q;  // scan index (one extra bit)
  logic          phase_q;
  logic [63:0]   acc_q, total_q, target_q;
  logic [7:0]    cut_q;
  logic          found_q;
  logic [63:0]   p99_q [2];
  logic [1:0]    dstep_q;
  logic [63:0]   quo_q [4];
  logic          dwait_q;

  logic [30:0] r_deliv_q, r_avg_q, r_mr_q, r_p99_q;
  logic [7:0]  r_cut_q;
  logic        oval_q;

  // RAMs
  logic              p_we, l_we;
  logic [7:0]        p_wa, p_ra;
  logic [LAW-1:0]    l_wa, l_ra;
  logic [31:0]       p_wd, l_wd, p_rd, l_rd;

  lhps_ram #(.WIDTH(32), .DEPTH(PDEPTH)) u_pram (
    .clk_i, .we_i(p_we), .waddr_i(p_wa), .wdata_i(p_wd), .raddr_i(p_ra), .rdata_o(p_rd));
  lhps_ram #(.WIDTH(32), .DEPTH(LDEPTH)) u_lram (
    .clk_i, .we_i(l_we), .waddr_i(l_wa), .wdata_i(l_wd), .raddr_i(l_ra), .rdata_o(l_rd));

  div_req_t dreq;
  div_rsp_t drsp;
  lhps_div u_div (.clk_i, .rst_ni, .req_i(dreq), .rsp_o(drsp));

  logic [7:0]  eff_lim;
  logic [7:0]  pbin;
  logic [LAW-1:0] lbin;
  logic        in_acc, cfg_acc;

  assign eff_lim = (limit_q > EFF_MAX) ? EFF_MAX : limit_q;
  assign pbin    = (parts_q > {8'd0, eff_lim}) ? eff_lim : parts_q[7:0];
  assign lbin    = {~cls_q, (dur_q > 32'(LAT_BUCKETS - 1)) ?
                   (LAW-1)'(LAT_BUCKETS - 1) : dur_q[LAW-2:0]};

  assign in_stall_o  = (state_q != ST_IDLE) || pclr_q;
  assign in_acc      = in_valid_i && !in_stall_o;
  assign cfg_ready_o = (state_q == ST_IDLE) && !pclr_q;
  assign cfg_acc     = cfg_valid_i && cfg_ready_o;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR:  if (clr_q == CW'(CLRN - 1)) state_d = ST_IDLE;
      ST_IDLE:   if (in_acc) state_d = (operation_i == OP_SNAPSHOT) ? ST_SCAN_P : ST_RMW;
      ST_RMW:    state_d = ST_IDLE;
      ST_SCAN_P: if (phase_q && idx_q[7:0] == eff_lim) state_d = ST_CUT_P;
      ST_CUT_P:  if (phase_q && (idx_q[7:0] == eff_lim || found_q)) state_d = ST_SCAN_L;
      ST_SCAN_L: if (phase_q && idx_q[LAW-1:0] == LAW'(LDEPTH - 1)) state_d = ST_DIV;
      ST_DIV:    if (drsp.done && dstep_q == 2'd3) state_d = ST_PACK;
      ST_PACK:   state_d = ST_OUT;
      ST_OUT:    if (!out_stall_i) state_d = ST_CLEAR;
      default:   state_d = ST_IDLE;
    endcase
  end

  // memory and divider controls
  always_comb begin
    p_we = 1'b0; p_wa = '0; p_wd = '0; p_ra = '0;
    l_we = 1'b0; l_wa = '0; l_wd = '0; l_ra = '0;
    dreq = '0;
    case (state_q)
      ST_CLEAR: begin
        p_we = 1'b1; p_wa = clr_q[7:0];
        l_we = 1'b1; l_wa = clr_q[LAW-1:0];
      end
      ST_IDLE: begin
        p_we = pclr_q; p_wa = clr_q[7:0];
        p_ra = (parts_i > {8'd0, eff_lim}) ? eff_lim : parts_i[7:0];
        l_ra = {~is_slot0_i, (duration_ms_i > 32'(LAT_BUCKETS - 1)) ?
               (LAW-1)'(LAT_BUCKETS - 1) : duration_ms_i[LAW-2:0]};
      end
      ST_RMW: begin
        p_we = (op_q == OP_PARTS) && (eff_lim != 8'd0);
        p_wa = pbin;
        p_wd = (p_rd == SAT32) ? p_rd : p_rd + 32'd1;
        l_we = (op_q == OP_USEFUL);
        l_wa = lbin;
        l_wd = (l_rd == SAT32) ? l_rd : l_rd + 32'd1;
      end
      ST_SCAN_P, ST_CUT_P: p_ra = idx_q[7:0];
      ST_SCAN_L: l_ra = idx_q[LAW-1:0];
      ST_DIV: begin
        dreq.start = !dwait_q;
        case (dstep_q)
          2'd0: begin dreq.num = lsum_q[0]; dreq.den = lcnt_q[0]; end
          2'd1: begin dreq.num = lsum_q[1]; dreq.den = lcnt_q[1]; end
          2'd2: begin
            dreq.num = 64'(rhit_q[0]) * 64'(REPAIR_SCALE) + 64'(rtot_q[0] >> 1);
            dreq.den = 64'(rtot_q[0]);
          end
          default: begin
            dreq.num = 64'(rhit_q[1]) * 64'(REPAIR_SCALE) + 64'(rtot_q[1] >> 1);
            dreq.den = 64'(rtot_q[1]);
          end
        endcase
      end
      default: ;
    endcase
  end

  function automatic logic [63:0] clampv(input logic [63:0] v, input logic [63:0] lim);
    clampv = (v > lim) ? lim : v;
  endfunction

  function automatic logic [30:0] sat31f(input logic [63:0] v);
    sat31f = (v > 64'(SAT31)) ? SAT31 : v[30:0];
  endfunction

  logic [63:0] a0, a1, rr0, rr1, pk, pp0, pp1;
  logic [63:0] pairv_avg, pairv_p99, mrw;
  logic [63:0] sum_next;
  logic [63:0] l_th;
  always_comb begin
    a0  = (lcnt_q[0] == 0) ? 64'd0 : clampv(quo_q[0], 64'(AVG_LIMIT));
    a1  = (lcnt_q[1] == 0) ? 64'd0 : clampv(quo_q[1], 64'(AVG_LIMIT));
    rr0 = (rtot_q[0] == 0) ? 64'd0 : clampv(quo_q[2], 64'(REPAIR_SCALE));
    rr1 = (rtot_q[1] == 0) ? 64'd0 : clampv(quo_q[3], 64'(REPAIR_SCALE));
    pk  = 64'((lpeak_q[0] > lpeak_q[1]) ? lpeak_q[0] : lpeak_q[1]);
    pk  = clampv(pk, 64'(MAX_MS_LIMIT));
    pp0 = clampv(p99_q[0], 64'(P99_LIMIT));
    pp1 = clampv(p99_q[1], 64'(P99_LIMIT));
    pairv_avg = a0 * 64'(AVG_LIMIT + 1) + a1;
    pairv_p99 = pp0 * 64'(P99_LIMIT + 1) + pp1;
    mrw = (pk << 16) | (rr0 << 8) | rr1;
    sum_next = lsum_q[~cls_q] + 64'(dur_q);
    l_th = lcnt_q[idx_q[LAW-1]] - ldq_q[idx_q[LAW-1]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      limit_q <= '0;
      clr_q   <= '0;
      pclr_q  <= 1'b0;
      oval_q  <= 1'b0;
      deliv_q <= '0;
      pdq_q   <= '0;
      pdr_q   <= '0;
      for (int c = 0; c < 2; c++) begin
        lcnt_q[c] <= '0; lsum_q[c] <= '0; lpeak_q[c] <= '0;
        rtot_q[c] <= '0; rhit_q[c] <= '0;
        ldq_q[c] <= '0; ldr_q[c] <= '0;
      end
      idx_q <= '0; phase_q <= 1'b0; dstep_q <= '0; dwait_q <= 1'b0;
      found_q <= 1'b0;
    end else begin
      state_q <= state_d;
      case (state_q)
        ST_CLEAR: begin
          clr_q <= (state_d == ST_IDLE) ? '0 : clr_q + CW'(1);
          deliv_q <= '0;
          pdq_q   <= '0;
          pdr_q   <= '0;
          for (int c = 0; c < 2; c++) begin
            lcnt_q[c] <= '0; lsum_q[c] <= '0; lpeak_q[c] <= '0;
            rtot_q[c] <= '0; rhit_q[c] <= '0;
            ldq_q[c] <= '0; ldr_q[c] <= '0;
          end
        end
        ST_IDLE: begin
          if (cfg_acc && cfg_data_i != limit_q) begin
            limit_q <= cfg_data_i;
            pclr_q  <= 1'b1;
            clr_q   <= '0;
            pdq_q   <= '0;
            pdr_q   <= '0;
          end else if (pclr_q) begin
            if (clr_q[7:0] == 8'd255) begin
              pclr_q <= 1'b0;
              clr_q  <= '0;
            end else begin
              clr_q <= clr_q + CW'(1);
            end
          end
          if (in_acc) begin
            op_q <= operation_i; parts_q <= parts_i; dur_q <= duration_ms_i;
            cls_q <= is_slot0_i; rep_q <= via_repair_i;
            idx_q <= '0; phase_q <= 1'b0; acc_q <= '0; found_q <= 1'b0;
            dstep_q <= '0; dwait_q <= 1'b0;
          end
        end
        ST_RMW: begin
          case (op_q)
            OP_DELIVERED: if (deliv_q != SAT64) deliv_q <= deliv_q + 64'd1;
            OP_PARTS: begin
              if (eff_lim != 8'd0 && p_rd != SAT32) begin
                if (pdr_q == 7'(PCT - 1)) begin
                  pdr_q <= '0;
                  pdq_q <= pdq_q + 64'd1;
                end else begin
                  pdr_q <= pdr_q + 7'd1;
                end
              end
            end
            OP_USEFUL: begin
              if (lcnt_q[~cls_q] != SAT64) begin
                lcnt_q[~cls_q] <= lcnt_q[~cls_q] + 64'd1;
                if (ldr_q[~cls_q] == 7'(PCT - 1)) begin
                  ldr_q[~cls_q] <= '0;
                  ldq_q[~cls_q] <= ldq_q[~cls_q] + 64'd1;
                end else begin
                  ldr_q[~cls_q] <= ldr_q[~cls_q] + 7'd1;
                end
              end
              lsum_q[~cls_q] <= (sum_next < lsum_q[~cls_q]) ? SAT64 : sum_next;
              if (dur_q > lpeak_q[~cls_q]) lpeak_q[~cls_q] <= dur_q;
            end
            OP_PART_RCV: begin
              if (rtot_q[~cls_q] != SAT32) rtot_q[~cls_q] <= rtot_q[~cls_q] + 32'd1;
              if (rep_q && rhit_q[~cls_q] != SAT32) rhit_q[~cls_q] <= rhit_q[~cls_q] + 32'd1;
            end
            default: ;
          endcase
        end
        ST_SCAN_P: begin
          // read issued in phase 0, data summed in phase 1
          phase_q <= ~phase_q;
          if (phase_q) begin
            if (idx_q[7:0] == eff_lim) begin
              total_q  <= acc_q + 64'(p_rd);
              target_q <= pdq_q + 64'd1;
              idx_q <= '0; acc_q <= '0;
            end else begin
              acc_q <= acc_q + 64'(p_rd);
              idx_q <= idx_q + (LAW+1)'(1);
            end
          end
        end
        ST_CUT_P: begin
          phase_q <= ~phase_q;
          if (phase_q) begin
            // hold the cutoff once found
            if (!found_q) begin
              if (total_q == 0) begin
                cut_q <= '0;
              end else if (acc_q + 64'(p_rd) >= target_q) begin
                cut_q <= idx_q[7:0];
              end else if (idx_q[7:0] == eff_lim) begin
                cut_q <= eff_lim;
              end
            end
            if (state_d == ST_SCAN_L) begin
              idx_q <= '0; acc_q <= '0; found_q <= 1'b0;
              p99_q[0] <= 64'(P99_LIMIT); p99_q[1] <= 64'(P99_LIMIT);
            end else begin
              acc_q <= acc_q + 64'(p_rd);
              idx_q <= idx_q + (LAW+1)'(1);
              if (!found_q && (total_q == 0 || acc_q + 64'(p_rd) >= target_q))
                found_q <= 1'b1;
            end
          end
        end
        ST_SCAN_L: begin
          phase_q <= ~phase_q;
          if (phase_q) begin
            if (lcnt_q[idx_q[LAW-1]] == 0) begin
              p99_q[idx_q[LAW-1]] <= '0;
            end else if (!found_q && acc_q + 64'(l_rd) >= l_th) begin
              p99_q[idx_q[LAW-1]] <= 64'(idx_q[LAW-2:0]) + 64'd1;
            end
            idx_q <= idx_q + (LAW+1)'(1);
            if (idx_q[LAW-2:0] == (LAW-1)'(LAT_BUCKETS - 1)) begin
              acc_q <= '0; found_q <= 1'b0;
            end else begin
              acc_q <= acc_q + 64'(l_rd);
              if (!found_q && lcnt_q[idx_q[LAW-1]] != 0 && acc_q + 64'(l_rd) >= l_th)
                found_q <= 1'b1;
            end
          end
        end
        ST_DIV: begin
          if (drsp.done) begin
            quo_q[dstep_q] <= drsp.quo;
            dstep_q <= dstep_q + 2'd1;
            dwait_q <= 1'b0;
          end else begin
            dwait_q <= 1'b1;
          end
        end
        ST_PACK: begin
          r_deliv_q <= sat31f(deliv_q);
          r_cut_q   <= cut_q;
          r_avg_q   <= sat31f(pairv_avg);
          r_mr_q    <= sat31f(mrw);
          r_p99_q   <= sat31f(pairv_p99);
          oval_q    <= 1'b1;
        end
        ST_OUT: if (!out_stall_i) oval_q <= 1'b0;
        default: ;
      endcase
    end
  end

  assign out_valid_o        = oval_q;
  assign delivered_count_o  = r_deliv_q;
  assign parts_low_cutoff_o = r_cut_q;
  assign avg_pair_o         = r_avg_q;
  assign max_and_repair_o   = r_mr_q;
  assign p99_pair_o         = r_p99_q;

  `LHPS_NEVER(a_no_in_busy, clk_i, rst_ni, in_acc && state_q != ST_IDLE, "item taken while busy")
  `LHPS_ASSERT(a_out_state, clk_i, rst_ni, out_valid_o |-> state_q == ST_OUT, "result outside output state")
  `LHPS_ASSERT(a_rmw_back, clk_i, rst_ni, state_q == ST_RMW |=> state_q == ST_IDLE, "update did not finish")
endmodule
`default_nettype wire
